>>> sv/kde_pkg.sv
// Shared types, constants and register codes for the kernel density evaluator.
package kde_pkg;

    localparam int MAX_SAMPLES = 1024;
    localparam int POINT_BITS  = 16;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int IDX_W       = 10;
    localparam int IBW_W       = 16;
    localparam int NORM_W      = 24;
    localparam int DENS_W      = 16;
    localparam int MAG_W       = POINT_BITS;
    localparam int P_W         = MAG_W + IBW_W;
    localparam int U_FRAC      = 20;
    localparam int PR_W        = U_FRAC + 1;
    localparam int SQ_W        = 2 * PR_W;
    localparam int TERM_W      = 12;
    localparam int TERM_MAX    = 3072;
    localparam int SUM_W       = $clog2(MAX_SAMPLES * TERM_MAX + 1);
    localparam int PROD_W      = SUM_W + NORM_W;
    localparam int DENS_SHIFT  = 16;
    localparam int APB_AW      = 4;
    localparam int APB_DW      = 32;

    localparam logic [P_W-1:0]  U_ONE    = P_W'(1) << U_FRAC;
    localparam logic [SQ_W-1:0] U_ONE_SQ = SQ_W'(1) << (2 * U_FRAC);

    localparam logic [1:0] REG_SAMPLE_COUNT  = 2'd0;
    localparam logic [1:0] REG_INV_BANDWIDTH = 2'd1;
    localparam logic [1:0] REG_NORM_SCALE    = 2'd2;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic                         req_type;
        logic [IDX_W-1:0]             sample_index;
        logic signed [POINT_BITS-1:0] point_value;
    } t_kde_in;

    typedef struct packed {
        logic [DENS_W-1:0] density;
        logic              saturated;
    } t_kde_out;

    typedef struct packed {
        logic [CNT_W-1:0]  sample_count;
        logic [IBW_W-1:0]  inv_bandwidth;
        logic [NORM_W-1:0] norm_scale;
    } t_kde_cfg;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_WALK  = 5'b00010,
        S_DRAIN = 5'b00100,
        S_SCALE = 5'b01000,
        S_DONE  = 5'b10000
    } t_kde_state;

endpackage

>>> sv/kde_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kde_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/kde_cfg.sv
// APB-style configuration registers of the kernel density evaluator.
module kde_cfg import kde_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_kde_cfg          o_cfg
);

    t_kde_cfg   r_cfg;
    logic       w_wr;
    logic [1:0] w_idx;

    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[3:2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_count  <= '0;
            r_cfg.inv_bandwidth <= IBW_W'(256);
            r_cfg.norm_scale    <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_SAMPLE_COUNT: begin
                    r_cfg.sample_count <= pwdata[CNT_W-1:0];
                end
                REG_INV_BANDWIDTH: begin
                    r_cfg.inv_bandwidth <= pwdata[IBW_W-1:0];
                end
                REG_NORM_SCALE: begin
                    r_cfg.norm_scale <= pwdata[NORM_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_SAMPLE_COUNT:  prdata = APB_DW'(r_cfg.sample_count);
            REG_INV_BANDWIDTH: prdata = APB_DW'(r_cfg.inv_bandwidth);
            REG_NORM_SCALE:    prdata = APB_DW'(r_cfg.norm_scale);
            default:           prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> sv/kde_term_pipe.sv
// Chain of registered cells that turns one stored sample a cycle into a kernel term.
module kde_term_pipe import kde_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic signed [POINT_BITS-1:0] i_sample,
    input  logic signed [POINT_BITS-1:0] i_query,
    input  logic [IBW_W-1:0]             i_inv_bw,
    output logic                         o_valid,
    output logic [TERM_W-1:0]            o_term,
    output logic                         o_busy
);

    logic signed [POINT_BITS:0] w_diff;
    logic [POINT_BITS:0]        w_abs;
    logic [SQ_W-1:0]            w_om;
    logic [SQ_W+1:0]            w_t3;
    logic                       w_ok;

    logic              r_v_mag, r_v_p, r_v_sq, r_v_term;
    logic [MAG_W-1:0]  r_mag;
    logic [P_W-1:0]    r_p;
    logic [SQ_W-1:0]   r_sq;
    logic              r_ok;
    logic [TERM_W-1:0] r_term;

    assign w_diff = (POINT_BITS+1)'(i_query) - (POINT_BITS+1)'(i_sample);
    assign w_abs  = w_diff[POINT_BITS] ? (POINT_BITS+1)'(-w_diff) : w_diff;
    assign w_ok   = (r_p <= U_ONE);
    assign w_om   = U_ONE_SQ - r_sq;
    assign w_t3   = (SQ_W+2)'(w_om) + ((SQ_W+2)'(w_om) << 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_mag  <= 1'b0;
            r_v_p    <= 1'b0;
            r_v_sq   <= 1'b0;
            r_v_term <= 1'b0;
        end else begin
            r_v_mag  <= i_valid;
            r_v_p    <= r_v_mag;
            r_v_sq   <= r_v_p;
            r_v_term <= r_v_sq;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag  <= w_abs[MAG_W-1:0];
        r_p    <= P_W'(r_mag) * P_W'(i_inv_bw);
        r_ok   <= w_ok;
        r_sq   <= SQ_W'(r_p[PR_W-1:0]) * SQ_W'(r_p[PR_W-1:0]);
        r_term <= r_ok ? w_t3[2*U_FRAC-10+TERM_W-1:2*U_FRAC-10] : '0;
    end

    assign o_valid = r_v_term;
    assign o_term  = r_term;
    assign o_busy  = r_v_mag || r_v_p || r_v_sq || r_v_term;

endmodule

>>> sv/epanechnikov_kde_eval_unit.sv
// Top level of the Epanechnikov kernel density evaluator.
//
//   channel   | direction | handshake                  | word
//   ----------+-----------+----------------------------+----------------------
//   input     | in        | i_in_valid / o_in_ready    | i_in_data (t_kde_in)
//   output    | out       | o_out_valid / i_out_ready  | o_out_data (t_kde_out)
//   config    | in        | psel, penable, pwrite      | paddr, pwdata, prdata
//
// A load word writes the sample store directly.
// A query sums the kernel terms of the first sample_count stored samples, which may be none:
// the store's single read port feeds the cell chain one sample per cycle, then the chain
// drains and the sum is scaled in the multiplier. Reset is synchronous and active low and
// leaves the store untouched. A waiting result blocks only the end of the next query.
module epanechnikov_kde_eval_unit import kde_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_kde_in           i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_kde_out          o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_kde_cfg   w_cfg;
    t_kde_state r_state, n_state;

    logic                         w_in_fire, w_query, w_load, w_issue, w_free;
    logic                         w_we;
    logic [CNT_W-1:0]             w_count;
    logic signed [POINT_BITS-1:0] w_sample;
    logic                         w_term_v, w_busy;
    logic [TERM_W-1:0]            w_term;

    logic [CNT_W-1:0]             r_walk, r_count;
    logic signed [POINT_BITS-1:0] r_query;
    logic                         r_v_rd;
    logic [SUM_W-1:0]             r_sum;
    logic [PROD_W-1:0]            r_prod;
    logic                         r_out_valid;
    t_kde_out                     r_out_data;

    kde_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_query    = w_in_fire && (i_in_data.req_type == REQ_QUERY);
    assign w_load     = w_in_fire && (i_in_data.req_type == REQ_LOAD);
    assign w_we       = w_load && ({1'b0, i_in_data.sample_index} < (IDX_W+1)'(MAX_SAMPLES));
    assign w_count    = (w_cfg.sample_count > CNT_W'(MAX_SAMPLES)) ? CNT_W'(MAX_SAMPLES)
                                                                   : w_cfg.sample_count;
    assign w_issue    = (r_state == S_WALK) && (r_walk != r_count);
    assign w_free     = !r_out_valid || i_out_ready;

    kde_ram #(
        .WIDTH (POINT_BITS),
        .DEPTH (MAX_SAMPLES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_in_data.sample_index[ADDR_W-1:0]),
        .i_wdata (i_in_data.point_value),
        .i_raddr (r_walk[ADDR_W-1:0]),
        .o_rdata (w_sample)
    );

    kde_term_pipe u_pipe (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_v_rd),
        .i_sample (w_sample),
        .i_query  (r_query),
        .i_inv_bw (w_cfg.inv_bandwidth),
        .o_valid  (w_term_v),
        .o_term   (w_term),
        .o_busy   (w_busy)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_query) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (r_walk == r_count) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_v_rd && !w_busy) begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_walk      <= '0;
            r_count     <= '0;
            r_v_rd      <= 1'b0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v_rd  <= w_issue;
            if (w_query) begin
                r_walk  <= '0;
                r_count <= w_count;
            end else if (w_issue) begin
                r_walk <= r_walk + CNT_W'(1);
            end
            if (w_query) begin
                r_sum <= '0;
            end else if (w_term_v) begin
                r_sum <= r_sum + SUM_W'(w_term);
            end
            if ((r_state == S_DONE) && w_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_query) begin
            r_query <= i_in_data.point_value;
        end
        if (r_state == S_SCALE) begin
            r_prod <= PROD_W'(r_sum) * PROD_W'(w_cfg.norm_scale);
        end
        if ((r_state == S_DONE) && w_free) begin
            if (r_prod[PROD_W-1:DENS_SHIFT+DENS_W] != '0) begin
                r_out_data.density   <= '1;
                r_out_data.saturated <= 1'b1;
            end else begin
                r_out_data.density   <= r_prod[DENS_SHIFT+DENS_W-1:DENS_SHIFT];
                r_out_data.saturated <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTHESIS
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_walk <= r_count))
        else $error("walk index ran past the sample count");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_v_rd && !w_busy))
        else $error("cell chain busy while idle");

    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && (n_state == S_IDLE)) |=> o_out_valid)
        else $error("finished query left no result");

    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.saturated) |-> (o_out_data.density == '1))
        else $error("saturated result is not at full scale");
`endif

endmodule
